### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the flash synchronizer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every edge outside reset.
`define FFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define FFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ffs_pkg.sv
// ----------------------------------------------------------------------------
// Flash synchronizer package
// Shared types, register codes and constants of the flash synchronizer.
// ----------------------------------------------------------------------------
package ffs_pkg;

  localparam int MSG_BUF_LEN = 15;
  localparam int PAYLOAD_MAX = MSG_BUF_LEN - 2;
  localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);

  localparam int TIME_W  = 32;
  localparam int DELAY_W = 20;
  localparam int THR_W   = 16;
  localparam int ACC_W   = 21;

  // Input operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_MAX_PEER_DELAY  = 2'd1;
  localparam logic [1:0] REG_SYNC_RATE       = 2'd2;
  localparam logic [1:0] REG_EARLY_THRESHOLD = 2'd3;

  // Reset values.
  localparam logic [DELAY_W-1:0] BASE_INTERVAL_RST   = 20'd19000;
  localparam logic [DELAY_W-1:0] MAX_PEER_DELAY_RST  = 20'd10000;
  localparam logic [DELAY_W-1:0] SYNC_RATE_RST       = 20'd1000;
  localparam logic [THR_W-1:0]   EARLY_THRESHOLD_RST = 16'd50;
  localparam logic [TIME_W-1:0]  NEXT_FLASH_RST      = 32'd19000;

  // Message framing characters.
  localparam logic [7:0] CHAR_START = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_END   = 8'h3C;  // '<'

  // Parser phases.
  localparam logic [1:0] PH_SKIP    = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_ENDED   = 2'd2;
  localparam logic [1:0] PH_INVALID = 2'd3;

  typedef struct packed {
    logic [DELAY_W-1:0] base_interval;
    logic [DELAY_W-1:0] max_peer_delay;
    logic [DELAY_W-1:0] sync_rate;
    logic [THR_W-1:0]   early_threshold;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] value;
  } peer_t;

  typedef struct packed {
    logic               flash_now;
    logic               early_flash;
    logic               adjusted;
    logic               send_sync;
    logic [DELAY_W-1:0] sync_delay;
  } result_t;

endpackage

### hw/rtl/ffs_parser.sv
// ----------------------------------------------------------------------------
// Message parser
// Parses received bytes of the form ">digits<" into a saturated peer delay.
// ----------------------------------------------------------------------------
module ffs_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_fire,
  input  logic [7:0]    byte_value,
  output ffs_pkg::peer_t peer
);

  logic                     in_msg_r, in_msg_nxt;
  logic [ffs_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic [ffs_pkg::ACC_W-1:0] acc_r, acc_nxt;

  logic                     is_space;
  logic                     is_digit;
  logic [3:0]               digit;
  logic [ffs_pkg::ACC_W+3:0] prod;
  logic [ffs_pkg::ACC_W-1:0] acc_step;

  assign is_space = (byte_value == 8'h20) || (byte_value >= 8'h09 && byte_value <= 8'h0D);
  assign is_digit = (byte_value >= 8'h30) && (byte_value <= 8'h39);
  assign digit    = byte_value[3:0];

  // Times ten as two shifts, then add the digit and saturate.
  always_comb begin
    prod = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {{ffs_pkg::ACC_W{1'b0}}, digit};
    if (prod[ffs_pkg::ACC_W+3:ffs_pkg::ACC_W] != 4'd0) begin
      acc_step = '1;
    end else begin
      acc_step = prod[ffs_pkg::ACC_W-1:0];
    end
  end

  always_comb begin
    in_msg_nxt = in_msg_r;
    count_nxt  = count_r;
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    peer.valid = 1'b0;
    peer.value = acc_r;
    if (byte_fire) begin
      if (byte_value == ffs_pkg::CHAR_START) begin
        in_msg_nxt = 1'b1;
        count_nxt  = '0;
        phase_nxt  = ffs_pkg::PH_SKIP;
        acc_nxt    = '0;
      end else if (in_msg_r) begin
        if (byte_value == ffs_pkg::CHAR_END) begin
          in_msg_nxt = 1'b0;
          peer.valid = (phase_r == ffs_pkg::PH_DIGITS) || (phase_r == ffs_pkg::PH_ENDED);
        end else if (count_r < ffs_pkg::CNT_W'(ffs_pkg::PAYLOAD_MAX)) begin
          count_nxt = count_r + 1'b1;
          unique case (phase_r)
            ffs_pkg::PH_SKIP: begin
              if (is_digit) begin
                phase_nxt = ffs_pkg::PH_DIGITS;
                acc_nxt   = {{(ffs_pkg::ACC_W-4){1'b0}}, digit};
              end else if (!is_space) begin
                phase_nxt = ffs_pkg::PH_INVALID;
              end
            end
            ffs_pkg::PH_DIGITS: begin
              if (is_digit) begin
                acc_nxt = acc_step;
              end else begin
                phase_nxt = ffs_pkg::PH_ENDED;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      count_r  <= '0;
      phase_r  <= ffs_pkg::PH_SKIP;
      acc_r    <= '0;
    end else begin
      in_msg_r <= in_msg_nxt;
      count_r  <= count_nxt;
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule

### hw/rtl/ffs_clock.sv
// ----------------------------------------------------------------------------
// Flash clock
// Millisecond time, flash schedule, sync requests and peer adoption.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffs_clock (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             op,
  input  ffs_pkg::peer_t   peer,
  input  ffs_pkg::cfg_t    cfg,
  output ffs_pkg::result_t res
);

  logic [ffs_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [ffs_pkg::TIME_W-1:0] next_r, next_nxt;
  logic [ffs_pkg::TIME_W-1:0] last_r, last_nxt;

  logic [ffs_pkg::TIME_W-1:0] now1;
  logic [ffs_pkg::TIME_W-1:0] base32;
  logic [ffs_pkg::TIME_W-1:0] tick_next;
  logic [ffs_pkg::TIME_W-1:0] since_sync;
  logic [ffs_pkg::TIME_W-1:0] remain;
  logic [ffs_pkg::TIME_W-1:0] theirs;
  logic                       flash;
  logic                       sync;
  logic                       in_range;
  logic                       earlier;
  logic                       near;

  assign base32     = {{(ffs_pkg::TIME_W-ffs_pkg::DELAY_W){1'b0}}, cfg.base_interval};
  assign now1       = now_r + 32'd1;
  assign flash      = now1 >= next_r;
  assign tick_next  = flash ? (now1 + base32) : next_r;
  assign since_sync = now1 - last_r;
  assign sync = since_sync > {{(ffs_pkg::TIME_W-ffs_pkg::DELAY_W){1'b0}}, cfg.sync_rate};
  assign remain     = (tick_next > now1) ? (tick_next - now1) : '0;

  assign in_range = peer.value <= {1'b0, cfg.max_peer_delay};
  assign theirs   = now_r + {{(ffs_pkg::TIME_W-ffs_pkg::ACC_W){1'b0}}, peer.value};
  assign earlier  = peer.valid && in_range && (theirs < next_r);
  assign near = peer.value < {{(ffs_pkg::ACC_W-ffs_pkg::THR_W){1'b0}}, cfg.early_threshold};

  always_comb begin
    now_nxt  = now_r;
    next_nxt = next_r;
    last_nxt = last_r;
    res      = '0;
    if (fire) begin
      if (op == ffs_pkg::OP_TICK) begin
        now_nxt       = now1;
        next_nxt      = tick_next;
        res.flash_now = flash;
        if (sync) begin
          last_nxt      = now1;
          res.send_sync = 1'b1;
          if (remain[ffs_pkg::TIME_W-1:ffs_pkg::DELAY_W] != '0) begin
            res.sync_delay = '1;
          end else begin
            res.sync_delay = remain[ffs_pkg::DELAY_W-1:0];
          end
        end
      end else if (earlier) begin
        res.adjusted = 1'b1;
        if (near) begin
          // A peer flash this close fires now and restarts our interval.
          res.early_flash = 1'b1;
          next_nxt        = now_r + base32;
        end else begin
          next_nxt = theirs;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      next_r <= ffs_pkg::NEXT_FLASH_RST;
      last_r <= '0;
    end else begin
      now_r  <= now_nxt;
      next_r <= next_nxt;
      last_r <= last_nxt;
    end
  end

  `FFS_ASSERT_NEXT(a_tick_advances, fire && op == ffs_pkg::OP_TICK, now_r == $past(now_r) + 32'd1, "tick did not advance time")
  `FFS_ASSERT_NEXT(a_byte_holds_time, fire && op == ffs_pkg::OP_BYTE, $stable(now_r) && $stable(last_r), "byte request moved time")

endmodule

### hw/rtl/firefly_flash_sync.sv
// ----------------------------------------------------------------------------
// Firefly flash synchronizer
// Pulse-coupled oscillator: schedules flashes, requests sync messages and
// adopts earlier peer flashes parsed from received bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each request is either a one
//   millisecond tick (in_op = 0) or a received serial byte (in_op = 1).
//   Result channel (out_valid / out_stall): exactly one result per request,
//   in order: flash_now and send_sync/sync_delay on ticks, early_flash and
//   adjusted on bytes that close a valid peer message.
//   Configuration (cfg_valid / cfg_ready): cfg_ready is always high; write
//   only while no request is in flight.
//   Path: the input register feeds one pass of parse and schedule logic
//   into the result register. Throughput: one request per cycle while the
//   result is not stalled.
//   Reset (synchronous, rst_n low): time and sync mark clear, the next flash
//   is at 19000 ms, the parser leaves any message, registers take defaults.
//   Stall: a stalled result holds; the input register keeps one more request
//   and in_stall rises only when both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module firefly_flash_sync (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_flash_now,
  output logic        out_early_flash,
  output logic        out_adjusted,
  output logic        out_send_sync,
  output logic [19:0] out_sync_delay,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  ffs_pkg::cfg_t    cfg_r;
  logic             s1_valid_r;
  logic             s1_op_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r;
  ffs_pkg::result_t res_r;

  logic             out_free;
  logic             advance;
  logic             in_take;
  ffs_pkg::peer_t   peer;
  ffs_pkg::result_t res;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_interval   <= ffs_pkg::BASE_INTERVAL_RST;
      cfg_r.max_peer_delay  <= ffs_pkg::MAX_PEER_DELAY_RST;
      cfg_r.sync_rate       <= ffs_pkg::SYNC_RATE_RST;
      cfg_r.early_threshold <= ffs_pkg::EARLY_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffs_pkg::REG_BASE_INTERVAL:   cfg_r.base_interval   <= cfg_data;
        ffs_pkg::REG_MAX_PEER_DELAY:  cfg_r.max_peer_delay  <= cfg_data;
        ffs_pkg::REG_SYNC_RATE:       cfg_r.sync_rate       <= cfg_data;
        ffs_pkg::REG_EARLY_THRESHOLD: cfg_r.early_threshold <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_byte_r <= in_byte_value;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  ffs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (advance && s1_op_r == ffs_pkg::OP_BYTE),
    .byte_value (s1_byte_r),
    .peer       (peer)
  );

  ffs_clock u_clock (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .op    (s1_op_r),
    .peer  (peer),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid       = out_valid_r;
  assign out_flash_now   = res_r.flash_now;
  assign out_early_flash = res_r.early_flash;
  assign out_adjusted    = res_r.adjusted;
  assign out_send_sync   = res_r.send_sync;
  assign out_sync_delay  = res_r.sync_delay;

  `FFS_ASSERT(a_tick_no_peer, !(out_valid_r && (res_r.flash_now || res_r.send_sync) && (res_r.early_flash || res_r.adjusted)), "tick and peer flags in one result")
  `FFS_ASSERT(a_delay_only_sync, !(out_valid_r && !res_r.send_sync && res_r.sync_delay != '0), "sync delay without sync request")

endmodule
